[design/bbc_pkg.sv]
package bbc_pkg;

   // Default stack depth and the width of the reported open count.
   localparam int STACK_DEPTH_DEFAULT = 64;
   localparam int OPEN_LEFT_W         = 7;
   localparam int OPEN_LEFT_MAX       = 127;

   // Bracket bytes in ASCII.
   localparam logic [7:0] CHAR_OPEN_ROUND   = 8'h28;
   localparam logic [7:0] CHAR_CLOSE_ROUND  = 8'h29;
   localparam logic [7:0] CHAR_OPEN_SQUARE  = 8'h5B;
   localparam logic [7:0] CHAR_CLOSE_SQUARE = 8'h5D;
   localparam logic [7:0] CHAR_OPEN_CURLY   = 8'h7B;
   localparam logic [7:0] CHAR_CLOSE_CURLY  = 8'h7D;

   // Kind of bracket as it is kept on the stack.
   typedef enum logic [1:0] {
      KIND_ROUND  = 2'd0,
      KIND_SQUARE = 2'd1,
      KIND_CURLY  = 2'd2
   } kind_type;

   // Decoded view of one input byte.
   typedef struct packed {
      logic     is_open;
      logic     is_close;
      kind_type kind;
   } class_type;

   // Input transaction payload.
   typedef struct packed {
      logic [7:0] char_code;
      logic       last_char;
   } req_type;

   // Result transaction payload.
   typedef struct packed {
      logic                   balanced;
      logic                   overflowed;
      logic [OPEN_LEFT_W-1:0] open_left;
   } rsp_type;

endpackage

[design/bbc_classify.sv]
module bbc_classify
   import bbc_pkg::*;
(
   input  logic [7:0] char_code,
   output class_type  cls
);

   // Map a byte to opener, closer or neither, along with its bracket kind.
   always_comb begin
      cls = '{is_open: 1'b0, is_close: 1'b0, kind: KIND_ROUND};
      unique case (char_code)
         CHAR_OPEN_ROUND: begin
            cls.is_open = 1'b1;
            cls.kind    = KIND_ROUND;
         end
         CHAR_CLOSE_ROUND: begin
            cls.is_close = 1'b1;
            cls.kind     = KIND_ROUND;
         end
         CHAR_OPEN_SQUARE: begin
            cls.is_open = 1'b1;
            cls.kind    = KIND_SQUARE;
         end
         CHAR_CLOSE_SQUARE: begin
            cls.is_close = 1'b1;
            cls.kind     = KIND_SQUARE;
         end
         CHAR_OPEN_CURLY: begin
            cls.is_open = 1'b1;
            cls.kind    = KIND_CURLY;
         end
         CHAR_CLOSE_CURLY: begin
            cls.is_close = 1'b1;
            cls.kind     = KIND_CURLY;
         end
         default: begin
            cls.is_open  = 1'b0;
            cls.is_close = 1'b0;
         end
      endcase
   end

endmodule

[design/bracket_balance_checker.sv]
// Streaming bracket balance check, one byte per transaction.
// Throughput: one byte per cycle; the top of stack is cached in a register and the
// entry below it is prefetched from the stack memory every cycle.
// The result is loaded into the output register when the last byte is taken.
// The input is stalled only in cycles where a finished result waits and is stalled.
// Reset clears the stack count, the overflow flag and the output valid; the stack
// memory is not cleared, since only entries below the count are ever used.
module bracket_balance_checker
   import bbc_pkg::*;
#(
   parameter int STACK_DEPTH = STACK_DEPTH_DEFAULT
)(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   localparam int CW = $clog2(STACK_DEPTH + 1);
   localparam int AW = $clog2(STACK_DEPTH);
   localparam int LW = (CW > OPEN_LEFT_W) ? CW : OPEN_LEFT_W;

   class_type cls;

   logic [CW-1:0] count_ff, count_in, count_upd;
   logic          ovf_ff, ovf_in, ovf_upd;
   kind_type      top_ff, top_in;
   kind_type      below_ff;
   logic [AW-1:0] rd_addr;
   logic          accept, last, do_pop, try_push, full, do_push, drop;
   logic [LW-1:0] count_ext;
   logic          rsp_valid_ff;
   rsp_type       rsp_data_ff;

   kind_type stack_mem [STACK_DEPTH];

   bbc_classify u_classify (
      .char_code (req_data.char_code),
      .cls       (cls)
   );

   // The input is held off only while a result waits and is itself stalled.
   assign req_stall = rsp_valid_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;
   assign last      = accept && req_data.last_char;

   // Pop on a matching closer, otherwise push an opener if there is room.
   assign do_pop   = accept && cls.is_close && (count_ff != '0) && (top_ff == cls.kind);
   assign try_push = accept && cls.is_open && !do_pop;
   assign full     = (count_ff == CW'(STACK_DEPTH));
   assign do_push  = try_push && !full;
   assign drop     = try_push && full;

   always_comb begin
      if (do_pop) begin
         count_upd = count_ff - CW'(1);
      end else if (do_push) begin
         count_upd = count_ff + CW'(1);
      end else begin
         count_upd = count_ff;
      end
      ovf_upd  = ovf_ff | drop;
      count_in = last ? '0 : count_upd;
      ovf_in   = last ? 1'b0 : ovf_upd;
   end

   // The cached top takes the pushed kind, or the prefetched entry below it on a pop.
   always_comb begin
      if (do_push) begin
         top_in = cls.kind;
      end else if (do_pop) begin
         top_in = below_ff;
      end else begin
         top_in = top_ff;
      end
   end

   // Prefetch the entry that will sit just below the top in the next cycle.
   assign rd_addr = (count_in >= CW'(2)) ? AW'(count_in - CW'(2)) : '0;

   // Stack memory: one write port for pushes, one registered read port.
   always_ff @(posedge clock) begin
      if (do_push) begin
         stack_mem[AW'(count_ff)] <= cls.kind;
      end
      below_ff <= stack_mem[rd_addr];
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         ovf_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         ovf_ff   <= ovf_in;
         if (last) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Top of stack cache.
   always_ff @(posedge clock) begin
      top_ff <= top_in;
   end

   // Result register, loaded on the last byte of a string.
   assign count_ext = LW'(count_upd);

   always_ff @(posedge clock) begin
      if (last) begin
         rsp_data_ff.balanced   <= (count_upd == '0) && !ovf_upd;
         rsp_data_ff.overflowed <= ovf_upd;
         rsp_data_ff.open_left  <= (count_ext > LW'(OPEN_LEFT_MAX)) ?
                                   OPEN_LEFT_W'(OPEN_LEFT_MAX) :
                                   count_ext[OPEN_LEFT_W-1:0];
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

[design/bbc_checker.sv]
module bbc_checker
   import bbc_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_stall,
   input req_type req_data,
   input logic    rsp_valid,
   input logic    rsp_stall,
   input rsp_type rsp_data
);

   // No result is pending right after reset.
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   // A stalled result holds its value.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result changed");

   // The last byte of a string always produces a result in the next cycle.
   a_last_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_data.last_char |=> rsp_valid)
      else $error("missing result after last byte");

   // A new result appears only after a last byte was taken.
   a_rsp_cause: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && !req_stall && req_data.last_char))
      else $error("result without a last byte");

   // Balanced means nothing left open and no overflow.
   a_balanced_consistent: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.balanced |-> !rsp_data.overflowed && (rsp_data.open_left == '0))
      else $error("inconsistent balanced result");

endmodule

bind bracket_balance_checker bbc_checker u_bbc_checker (.*);
